[hw/rtl/ile_pkg.sv]
package ile_pkg;

	localparam int CAPACITY = 64;
	localparam int SLOT_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int OP_W     = 3;
	localparam int STAT_W   = 2;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [DATA_W-1:0] word_t;
	typedef logic [OP_W-1:0]   op_t;
	typedef logic [STAT_W-1:0] stat_t;

	localparam cnt_t CNT_CAP  = cnt_t'(CAPACITY);
	localparam cnt_t CNT_LAST = cnt_t'(CAPACITY - 1);

	localparam op_t OP_READ     = op_t'(0);
	localparam op_t OP_INS_HEAD = op_t'(1);
	localparam op_t OP_INS_TAIL = op_t'(2);
	localparam op_t OP_INS_POS  = op_t'(3);
	localparam op_t OP_DELETE   = op_t'(4);

	localparam stat_t ST_OK    = stat_t'(0);
	localparam stat_t ST_RANGE = stat_t'(1);
	localparam stat_t ST_FULL  = stat_t'(2);

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP,
		S_WALK,
		S_LINK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic  val_we;
		slot_t val_addr;
		word_t val_data;
		logic  nxt_we;
		slot_t nxt_addr;
		slot_t nxt_data;
		logic  prv_we;
		slot_t prv_addr;
		slot_t prv_data;
	} node_wr_t;

	typedef struct packed {
		word_t value;
		slot_t nxt;
		slot_t prv;
	} node_rd_t;

	typedef struct packed {
		word_t read_data;
		logic  hit;
		stat_t status;
		cnt_t  length;
	} res_t;

endpackage

[hw/rtl/ile_node_store.sv]
module ile_node_store (
	input  logic              clk,
	input  logic              rd_en,
	input  ile_pkg::slot_t    rd_addr,
	output ile_pkg::node_rd_t rd_data,
	input  ile_pkg::node_wr_t wr
);

	ile_pkg::word_t value_mem [ile_pkg::CAPACITY];
	ile_pkg::slot_t next_mem  [ile_pkg::CAPACITY];
	ile_pkg::slot_t prev_mem  [ile_pkg::CAPACITY];

	ile_pkg::node_rd_t rd_q;

	always_ff @(posedge clk) begin
		if (wr.val_we) begin
			value_mem[wr.val_addr] <= wr.val_data;
		end
		if (wr.nxt_we) begin
			next_mem[wr.nxt_addr] <= wr.nxt_data;
		end
		if (wr.prv_we) begin
			prev_mem[wr.prv_addr] <= wr.prv_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q.value <= value_mem[rd_addr];
			rd_q.nxt   <= next_mem[rd_addr];
			rd_q.prv   <= prev_mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

[hw/rtl/ile_free_stack.sv]
module ile_free_stack (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rd_en,
	input  ile_pkg::slot_t rd_addr,
	output ile_pkg::slot_t rd_slot,
	input  logic           push_en,
	input  ile_pkg::slot_t push_addr,
	input  ile_pkg::slot_t push_data
);

	// entries never pushed read as their own index
	ile_pkg::slot_t                    stack_mem [ile_pkg::CAPACITY];
	logic [ile_pkg::CAPACITY-1:0]      written_q;
	ile_pkg::slot_t                    rd_q;
	ile_pkg::slot_t                    rd_addr_q;
	logic                              rd_written_q;

	always_ff @(posedge clk) begin
		if (push_en) begin
			stack_mem[push_addr] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (push_en) begin
			written_q[push_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q         <= stack_mem[rd_addr];
			rd_written_q <= written_q[rd_addr];
			rd_addr_q    <= rd_addr;
		end
	end

	assign rd_slot = rd_written_q ? rd_q : rd_addr_q;

endmodule

[hw/rtl/ile_ctrl.sv]
module ile_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ile_pkg::op_t      opcode,
	input  ile_pkg::cnt_t     position,
	input  ile_pkg::word_t    data_in,
	output logic              node_rd_en,
	output ile_pkg::slot_t    node_rd_addr,
	input  ile_pkg::node_rd_t node_rd,
	output ile_pkg::node_wr_t node_wr,
	output logic              stk_rd_en,
	output ile_pkg::slot_t    stk_rd_addr,
	input  ile_pkg::slot_t    free_slot,
	output logic              stk_push_en,
	output ile_pkg::slot_t    stk_push_addr,
	output ile_pkg::slot_t    stk_push_data,
	output logic              res_valid,
	input  logic              res_ready,
	output ile_pkg::res_t     res
);

	ile_pkg::state_t state_q, state_d;
	ile_pkg::slot_t  first_q, last_q, cur_q;
	ile_pkg::cnt_t   count_q, pos_q, steps_q;
	ile_pkg::op_t    op_q;
	ile_pkg::word_t  data_q, rdata_q;
	logic            hit_q;
	ile_pkg::stat_t  status_q;

	ile_pkg::state_t dec_state;
	ile_pkg::op_t    dec_op;
	ile_pkg::stat_t  dec_status;
	logic            dec_miss;
	logic            dec_pop;
	logic            full;
	logic            walk_end;
	logic            del_last;

	assign full     = (count_q == ile_pkg::CNT_CAP);
	assign walk_end = (steps_q == '0);
	assign del_last = ((pos_q + ile_pkg::cnt_t'(1)) == count_q);

	// classify the incoming transaction
	always_comb begin
		dec_state  = ile_pkg::S_DONE;
		dec_op     = opcode;
		dec_status = ile_pkg::ST_OK;
		dec_miss   = 1'b0;
		dec_pop    = 1'b0;
		case (opcode)
			ile_pkg::OP_READ: begin
				if (position < count_q) begin
					dec_state = ile_pkg::S_WALK;
				end else begin
					dec_status = ile_pkg::ST_RANGE;
					dec_miss   = 1'b1;
				end
			end
			ile_pkg::OP_INS_HEAD, ile_pkg::OP_INS_TAIL: begin
				if (full) begin
					dec_status = ile_pkg::ST_FULL;
				end else begin
					dec_state = ile_pkg::S_POP;
					dec_pop   = 1'b1;
				end
			end
			ile_pkg::OP_INS_POS: begin
				if (position > count_q) begin
					dec_status = ile_pkg::ST_RANGE;
				end else if (full) begin
					dec_status = ile_pkg::ST_FULL;
				end else if (position == '0) begin
					dec_state = ile_pkg::S_POP;
					dec_op    = ile_pkg::OP_INS_HEAD;
					dec_pop   = 1'b1;
				end else if (position == count_q) begin
					dec_state = ile_pkg::S_POP;
					dec_op    = ile_pkg::OP_INS_TAIL;
					dec_pop   = 1'b1;
				end else begin
					dec_state = ile_pkg::S_WALK;
					dec_pop   = 1'b1;
				end
			end
			ile_pkg::OP_DELETE: begin
				if (position >= count_q) begin
					dec_status = ile_pkg::ST_RANGE;
				end else begin
					dec_state = ile_pkg::S_WALK;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ile_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = dec_state;
				end
			end
			ile_pkg::S_POP: begin
				state_d = ile_pkg::S_DONE;
			end
			ile_pkg::S_WALK: begin
				if (walk_end) begin
					state_d = (op_q == ile_pkg::OP_INS_POS) ? ile_pkg::S_LINK : ile_pkg::S_DONE;
				end
			end
			ile_pkg::S_LINK: begin
				state_d = ile_pkg::S_DONE;
			end
			ile_pkg::S_DONE: begin
				if (res_ready) begin
					state_d = ile_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ile_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		node_rd_en    = 1'b0;
		node_rd_addr  = first_q;
		node_wr       = '0;
		stk_rd_en     = 1'b0;
		stk_rd_addr   = ile_pkg::slot_t'(ile_pkg::CNT_LAST - count_q);
		stk_push_en   = 1'b0;
		stk_push_addr = ile_pkg::slot_t'(ile_pkg::CNT_CAP - count_q);
		stk_push_data = cur_q;
		res_valid     = 1'b0;
		case (state_q)
			ile_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					node_rd_en = (dec_state == ile_pkg::S_WALK);
					stk_rd_en  = dec_pop;
				end
			end
			ile_pkg::S_POP: begin
				node_wr.val_we   = 1'b1;
				node_wr.val_addr = free_slot;
				node_wr.val_data = data_q;
				if (count_q != '0) begin
					if (op_q == ile_pkg::OP_INS_HEAD) begin
						node_wr.nxt_we   = 1'b1;
						node_wr.nxt_addr = free_slot;
						node_wr.nxt_data = first_q;
						node_wr.prv_we   = 1'b1;
						node_wr.prv_addr = first_q;
						node_wr.prv_data = free_slot;
					end else begin
						node_wr.prv_we   = 1'b1;
						node_wr.prv_addr = free_slot;
						node_wr.prv_data = last_q;
						node_wr.nxt_we   = 1'b1;
						node_wr.nxt_addr = last_q;
						node_wr.nxt_data = free_slot;
					end
				end
			end
			ile_pkg::S_WALK: begin
				if (!walk_end) begin
					node_rd_en   = 1'b1;
					node_rd_addr = node_rd.nxt;
				end else if (op_q == ile_pkg::OP_DELETE) begin
					node_wr.nxt_we   = (pos_q != '0);
					node_wr.nxt_addr = node_rd.prv;
					node_wr.nxt_data = node_rd.nxt;
					node_wr.prv_we   = !del_last;
					node_wr.prv_addr = node_rd.nxt;
					node_wr.prv_data = node_rd.prv;
					stk_push_en      = 1'b1;
				end else if (op_q == ile_pkg::OP_INS_POS) begin
					node_wr.val_we   = 1'b1;
					node_wr.val_addr = free_slot;
					node_wr.val_data = data_q;
					node_wr.nxt_we   = 1'b1;
					node_wr.nxt_addr = node_rd.prv;
					node_wr.nxt_data = free_slot;
					node_wr.prv_we   = 1'b1;
					node_wr.prv_addr = free_slot;
					node_wr.prv_data = node_rd.prv;
				end
			end
			ile_pkg::S_LINK: begin
				node_wr.nxt_we   = 1'b1;
				node_wr.nxt_addr = free_slot;
				node_wr.nxt_data = cur_q;
				node_wr.prv_we   = 1'b1;
				node_wr.prv_addr = cur_q;
				node_wr.prv_data = free_slot;
			end
			ile_pkg::S_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ile_pkg::S_IDLE;
			first_q <= '0;
			last_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ile_pkg::S_POP: begin
					count_q <= count_q + ile_pkg::cnt_t'(1);
					if (op_q == ile_pkg::OP_INS_HEAD) begin
						first_q <= free_slot;
						if (count_q == '0) begin
							last_q <= free_slot;
						end
					end else begin
						last_q <= free_slot;
						if (count_q == '0) begin
							first_q <= free_slot;
						end
					end
				end
				ile_pkg::S_WALK: begin
					if (walk_end && op_q == ile_pkg::OP_DELETE) begin
						count_q <= count_q - ile_pkg::cnt_t'(1);
						if (pos_q == '0) begin
							first_q <= node_rd.nxt;
						end
						if (del_last) begin
							last_q <= node_rd.prv;
						end
					end else if (walk_end && op_q == ile_pkg::OP_INS_POS) begin
						count_q <= count_q + ile_pkg::cnt_t'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ile_pkg::S_IDLE && in_valid) begin
			op_q     <= dec_op;
			pos_q    <= position;
			data_q   <= data_in;
			steps_q  <= position;
			cur_q    <= first_q;
			rdata_q  <= dec_miss ? '1 : '0;
			hit_q    <= 1'b0;
			status_q <= dec_status;
		end else if (state_q == ile_pkg::S_WALK) begin
			if (!walk_end) begin
				steps_q <= steps_q - ile_pkg::cnt_t'(1);
				cur_q   <= node_rd.nxt;
			end else if (op_q == ile_pkg::OP_READ) begin
				rdata_q <= node_rd.value;
				hit_q   <= 1'b1;
			end
		end
	end

	assign res.read_data = rdata_q;
	assign res.hit       = hit_q;
	assign res.status    = status_q;
	assign res.length    = count_q;

endmodule

[hw/rtl/indexed_list_engine.sv]
// Bounded doubly linked list of up to 64 signed 32-bit values. Each request
// transaction (read, insert at head, insert at tail, insert before a position,
// delete at a position) returns exactly one response transaction carrying the
// read value, hit flag, status and resulting length. One request is in work
// at a time. A positional request at position p walks the next links through
// the node store's single read port, one link per cycle. Read and delete go
// from acceptance through S_WALK to S_DONE; insert before a position goes
// through S_WALK and S_LINK to S_DONE. Head and tail inserts go through
// S_POP to S_DONE; refused or out-of-range requests go straight to S_DONE.
// The response register lets a new request be taken while the previous
// response is still waiting. No clearing pass is needed after reset.
module indexed_list_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [2:0]  opcode,
	input  logic [6:0]  position,
	input  logic signed [31:0] data_in,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic signed [31:0] read_data,
	output logic        hit,
	output logic [1:0]  status,
	output logic [6:0]  length
);

	logic              node_rd_en;
	ile_pkg::slot_t    node_rd_addr;
	ile_pkg::node_rd_t node_rd;
	ile_pkg::node_wr_t node_wr;
	logic              stk_rd_en;
	ile_pkg::slot_t    stk_rd_addr;
	ile_pkg::slot_t    free_slot;
	logic              stk_push_en;
	ile_pkg::slot_t    stk_push_addr;
	ile_pkg::slot_t    stk_push_data;
	logic              res_valid;
	logic              res_ready;
	ile_pkg::res_t     res;

	logic              rsp_valid_q;
	ile_pkg::res_t     rsp_q;

	ile_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (req_valid),
		.in_ready      (req_ready),
		.opcode        (opcode),
		.position      (position),
		.data_in       (data_in),
		.node_rd_en    (node_rd_en),
		.node_rd_addr  (node_rd_addr),
		.node_rd       (node_rd),
		.node_wr       (node_wr),
		.stk_rd_en     (stk_rd_en),
		.stk_rd_addr   (stk_rd_addr),
		.free_slot     (free_slot),
		.stk_push_en   (stk_push_en),
		.stk_push_addr (stk_push_addr),
		.stk_push_data (stk_push_data),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res)
	);

	ile_node_store u_nodes (
		.clk     (clk),
		.rd_en   (node_rd_en),
		.rd_addr (node_rd_addr),
		.rd_data (node_rd),
		.wr      (node_wr)
	);

	ile_free_stack u_free (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (stk_rd_en),
		.rd_addr   (stk_rd_addr),
		.rd_slot   (free_slot),
		.push_en   (stk_push_en),
		.push_addr (stk_push_addr),
		.push_data (stk_push_data)
	);

	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign read_data = rsp_q.read_data;
	assign hit       = rsp_q.hit;
	assign status    = rsp_q.status;
	assign length    = rsp_q.length;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous transaction still in work");

	a_hit_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && hit |-> status == ile_pkg::ST_OK)
		else $error("hit flagged with non-zero status");

	a_full_length: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ile_pkg::ST_FULL |-> length == ile_pkg::CNT_CAP)
		else $error("insert refused while list not full");

	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ile_pkg::ST_RANGE && read_data != 32'sd0
		|-> read_data == -32'sd1)
		else $error("out-of-range response carries a stray value");

endmodule

[tb/tb_indexed_list_engine.sv]
module tb_indexed_list_engine;
	import ile_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int TAIL_CYCLES = 80;
	localparam int RANDOM_ITEMS = 500;

	typedef struct packed {
		op_t        op;
		logic [6:0] pos;
		word_t      data;
	} list_req_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	op_t                opcode = OP_READ;
	logic [6:0]         position = '0;
	logic signed [31:0] data_in = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	logic signed [31:0] read_data;
	logic               hit;
	logic [1:0]         status;
	logic [6:0]         length;

	list_req_t pending_reqs[$];
	res_t      expected_rsps[$];
	word_t     list_values[$];
	int        gen_len = 0;
	int        req_count = 0;
	int        rsp_count = 0;
	int        err_count = 0;
	int        stall_cycles = 0;
	logic      steady;

	assign steady = (req_count >= 200) && (req_count < 300);

	indexed_list_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.opcode    (opcode),
		.position  (position),
		.data_in   (data_in),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.read_data (read_data),
		.hit       (hit),
		.status    (status),
		.length    (length)
	);

	initial forever #1 clk = ~clk;

	// applies one request to the list contents and returns the response it should give
	function automatic res_t list_apply(op_t op, logic [6:0] pos, word_t din);
		res_t r;
		logic full;
		r = '0;
		full = list_values.size() >= CAPACITY;
		case (op)
			OP_READ: begin
				if (pos < list_values.size()) begin
					r.read_data = list_values[pos];
					r.hit = 1'b1;
				end else begin
					r.read_data = '1;
					r.status = ST_RANGE;
				end
			end
			OP_INS_HEAD: begin
				if (full) r.status = ST_FULL;
				else list_values.push_front(din);
			end
			OP_INS_TAIL: begin
				if (full) r.status = ST_FULL;
				else list_values.push_back(din);
			end
			OP_INS_POS: begin
				if (pos > list_values.size()) r.status = ST_RANGE;
				else if (full) r.status = ST_FULL;
				else list_values.insert(int'(pos), din);
			end
			OP_DELETE: begin
				if (pos >= list_values.size()) r.status = ST_RANGE;
				else list_values.delete(int'(pos));
			end
			default: ;
		endcase
		r.length = cnt_t'(list_values.size());
		return r;
	endfunction

	// gen_len follows the list length so that positions can be aimed at live elements
	task automatic queue_item(op_t op, logic [6:0] pos, word_t d);
		pending_reqs.push_back('{op, pos, d});
		case (op)
			OP_INS_HEAD, OP_INS_TAIL: if (gen_len < CAPACITY) gen_len++;
			OP_INS_POS: if (pos <= gen_len && gen_len < CAPACITY) gen_len++;
			OP_DELETE: if (pos < gen_len) gen_len--;
			default: ;
		endcase
	endtask

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
		if (err_count < 200)
			$display("mismatch on %s, response %0d: got %0h, expected %0h",
				field, rsp_count, got, want);
		err_count++;
	endtask

	// driver
	always @(posedge clk) begin
		list_req_t nxt;
		if (arst_n && (!req_valid || req_ready)) begin
			if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= 35)) begin
				nxt = pending_reqs.pop_front();
				req_valid <= 1'b1;
				opcode <= nxt.op;
				position <= nxt.pos;
				data_in <= nxt.data;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			rsp_ready <= steady || ($urandom_range(99) >= 35);
	end

	// monitor
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				expected_rsps.push_back(list_apply(opcode, position, data_in));
				req_count++;
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					report_mismatch("unexpected transaction", 32'(length), '0);
				end else begin
					want = expected_rsps.pop_front();
					if (read_data !== want.read_data)
						report_mismatch("read_data", read_data, want.read_data);
					if (hit !== want.hit)
						report_mismatch("hit", 32'(hit), 32'(want.hit));
					if (status !== want.status)
						report_mismatch("status", 32'(status), 32'(want.status));
					if (length !== want.length)
						report_mismatch("length", 32'(length), 32'(want.length));
				end
				rsp_count++;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles == STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int         r;
		int         insert_pct;
		op_t        op;
		logic [6:0] pos;
		word_t      d;
		bit         grow;

		// directed: empty list, extremes, ends and middle, out of range, unused opcodes
		queue_item(OP_READ, 7'd0, 32'd0);
		queue_item(OP_DELETE, 7'd0, 32'd0);
		queue_item(OP_INS_POS, 7'd1, 32'h1234_5678);
		queue_item(OP_INS_POS, 7'd0, 32'h7FFF_FFFF);
		queue_item(OP_INS_HEAD, 7'd127, 32'h8000_0000);
		queue_item(OP_INS_TAIL, 7'd0, 32'hFFFF_FFFF);
		queue_item(OP_INS_POS, 7'd3, 32'h0000_0000);
		queue_item(OP_INS_POS, 7'd2, 32'h5A5A_5A5A);
		queue_item(OP_INS_POS, 7'd127, 32'hA5A5_A5A5);
		for (int i = 0; i < 6; i++)
			queue_item(OP_READ, 7'(i), 32'd0);
		queue_item(OP_READ, 7'd127, 32'hFFFF_FFFF);
		queue_item(op_t'(5), 7'd127, 32'hFFFF_FFFF);
		queue_item(op_t'(6), 7'd64, 32'h8000_0000);
		queue_item(op_t'(7), 7'd0, 32'h7FFF_FFFF);
		queue_item(OP_DELETE, 7'd127, 32'd0);
		queue_item(OP_DELETE, 7'd2, 32'd0);
		queue_item(OP_DELETE, 7'd0, 32'd0);
		queue_item(OP_DELETE, 7'd2, 32'd0);
		queue_item(OP_READ, 7'd0, 32'd0);
		queue_item(OP_READ, 7'd1, 32'd0);

		// random: alternate filling towards full and draining towards empty
		grow = 1'b1;
		repeat (RANDOM_ITEMS) begin
			if (gen_len == CAPACITY && $urandom_range(7) == 0) grow = 1'b0;
			if (gen_len == 0) grow = 1'b1;
			if ($urandom_range(49) == 0) grow = ~grow;
			insert_pct = grow ? 60 : 12;
			r = $urandom_range(99);
			if (r < 3) op = op_t'($urandom_range(5, 7));
			else if (r < 28) op = OP_READ;
			else if (r < 28 + insert_pct)
				op = ($urandom_range(1) == 0) ? OP_INS_POS : op_t'($urandom_range(1, 2));
			else op = OP_DELETE;

			if (op == OP_INS_POS) begin
				if ($urandom_range(9) == 0) pos = 7'($urandom_range(gen_len + 1, 127));
				else pos = 7'($urandom_range(0, gen_len));
			end else if (op == OP_READ || op == OP_DELETE) begin
				if ($urandom_range(9) == 0 || gen_len == 0)
					pos = 7'($urandom_range(gen_len, 127));
				else
					pos = 7'($urandom_range(0, gen_len - 1));
			end else begin
				pos = 7'($urandom);
			end

			case ($urandom_range(7))
				0: d = 32'h8000_0000;
				1: d = 32'h7FFF_FFFF;
				default: d = $urandom;
			endcase
			queue_item(op, pos, d);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || req_valid) @(posedge clk);
		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
